>>> rtl/svacc_pkg.sv
// svacc_pkg: request/result types, format codes and register addresses
// for the scaled vector accumulate core and its checker
// no dependencies
package svacc_pkg;

	// element format codes
	localparam logic [1:0] FMT_FP32 = 2'd0;
	localparam logic [1:0] FMT_FP16 = 2'd1;
	localparam logic [1:0] FMT_BF16 = 2'd2;

	// register byte addresses
	localparam logic [2:0] ADDR_FORMAT = 3'd0;
	localparam logic [2:0] ADDR_SCALE  = 3'd4;

	// fp32 constants
	localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
	localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
	localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;

	// cycles from accepted request to result strobe
	localparam int PIPE_DEPTH = 9;

	typedef struct packed {
		logic [31:0] x_value;
		logic [31:0] y_value;
		logic        last_element;
	} request_t;

	typedef struct packed {
		logic [31:0] sum_value;
		logic        last_out;
	} result_t;

endpackage

>>> rtl/scaled_vector_accumulate_core.sv
// scaled_vector_accumulate_core: pipelined y + scale*x in fp32, fp16 or bf16
// depends on svacc_pkg (types, format codes, register addresses)
//
//   channel   | ports                                      | transfer
//   ----------+--------------------------------------------+---------------------------
//   request   | start, busy, request                       | start high, busy low
//   result    | done, result                               | done high for one cycle
//   config    | psel penable pwrite paddr pwdata prdata    | psel & penable & pwrite
//             | pready                                     |
//
// one request per cycle; each result passes through the registered stages
// widen, unpack, multiply, round product, align, add, normalize, round, narrow
// busy is never raised and the result side has no back pressure
// reset clears the stage valid bits and sets format fp32 and scale 1.0
module scaled_vector_accumulate_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  svacc_pkg::request_t request,
	output logic                done,
	output svacc_pkg::result_t  result
);

	typedef struct packed {
		logic       sign;
		logic [9:0] exp;
		logic [23:0] mant;
	} unp_t;

	typedef struct packed {
		logic [1:0] fmt;
		logic       last;
	} ctl_t;

	// fp16 to fp32, exact
	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] lz;
		logic [9:0] mn;
		logic found;
		logic [31:0] r;
		e = h[14:10];
		m = h[9:0];
		lz = '0;
		found = 1'b0;
		for (int i = 9; i >= 0; i--) begin
			if (!found && m[i]) begin
				lz = 4'(9 - i);
				found = 1'b1;
			end
		end
		mn = m << (lz + 4'd1);
		if (e == 5'h1F) begin
			r = (m != '0) ? {h[15], 8'hFF, 1'b1, m[8:0], 13'b0} : {h[15], 8'hFF, 23'b0};
		end else if (e == 5'h00) begin
			r = (m == '0) ? {h[15], 31'b0} : {h[15], 8'd112 - {4'b0, lz}, mn, 13'b0};
		end else begin
			r = {h[15], {3'b0, e} + 8'd112, m, 13'b0};
		end
		return r;
	endfunction

	// fp32 to fp16, round to nearest even
	function automatic logic [15:0] single_to_half(input logic [31:0] b);
		logic [7:0] e;
		logic [22:0] m;
		logic signed [9:0] e16;
		logic [14:0] v;
		logic [12:0] rem;
		logic signed [9:0] shw;
		logic [4:0] sh;
		logic [47:0] ext;
		logic inc;
		logic [15:0] r;
		e = b[30:23];
		m = b[22:0];
		e16 = $signed({2'b0, e}) - 10'sd112;
		shw = 10'sd14 - e16;
		sh = shw[4:0];
		ext = {1'b1, m, 24'b0} >> sh;
		rem = m[12:0];
		if (e == 8'hFF) begin
			r = (m != '0) ? {b[31], 5'h1F, 1'b1, m[21:13]} : {b[31], 15'h7C00};
		end else if (e16 >= 10'sd31) begin
			r = {b[31], 15'h7C00};
		end else if (e16 >= 10'sd1) begin
			v = {e16[4:0], m[22:13]};
			inc = (rem > 13'h1000) || (rem == 13'h1000 && v[0]);
			r = {b[31], v + {14'b0, inc}};
		end else if (e == 8'd0 || shw > 10'sd24) begin
			r = {b[31], 15'b0};
		end else begin
			v = ext[38:24];
			inc = ext[23] && ((|ext[22:0]) || v[0]);
			r = {b[31], v + {14'b0, inc}};
		end
		return r;
	endfunction

	// fp32 to bf16, round to nearest even
	function automatic logic [15:0] single_to_bf16(input logic [31:0] b);
		logic [31:0] t;
		t = b + 32'h0000_7FFF + {31'b0, b[16]};
		if (b[30:23] == 8'hFF && b[22:0] != '0) begin
			return b[31:16] | 16'h0040;
		end
		return t[31:16];
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != '0);
	endfunction

	function automatic logic is_inf(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] == '0);
	endfunction

	// split an fp32 value and bring subnormals to a leading one
	function automatic unp_t unpack_norm(input logic [31:0] a);
		unp_t u;
		logic [23:0] m;
		logic [4:0] lz;
		logic found;
		m = {a[30:23] != 8'd0, a[22:0]};
		lz = '0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found && m[i]) begin
				lz = 5'(23 - i);
				found = 1'b1;
			end
		end
		u.sign = a[31];
		u.mant = m << lz;
		u.exp = ((a[30:23] == 8'd0) ? 10'd1 : {2'b0, a[30:23]}) - {5'b0, lz};
		return u;
	endfunction

	// configuration registers
	logic [1:0]  fmt_q;
	logic [31:0] scale_q;
	logic        cfg_wr;

	assign cfg_wr = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q   <= svacc_pkg::FMT_FP32;
			scale_q <= svacc_pkg::SCALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr)
				svacc_pkg::ADDR_FORMAT: fmt_q <= pwdata[1:0];
				svacc_pkg::ADDR_SCALE:  scale_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (paddr)
			svacc_pkg::ADDR_FORMAT: prdata = {30'b0, fmt_q};
			svacc_pkg::ADDR_SCALE:  prdata = scale_q;
			default:                prdata = '0;
		endcase
	end

	assign busy = 1'b0;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9} <=
				{start & ~busy, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8};
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= '{fmt: fmt_q, last: request.last_element};
		ctl_s2 <= ctl_s1;
		ctl_s3 <= ctl_s2;
		ctl_s4 <= ctl_s3;
		ctl_s5 <= ctl_s4;
		ctl_s6 <= ctl_s5;
		ctl_s7 <= ctl_s6;
		ctl_s8 <= ctl_s7;
	end

	// stage 1: widen elements to fp32
	logic [31:0] x_s1, y_s1;

	always_ff @(posedge clk) begin
		case (fmt_q)
			svacc_pkg::FMT_FP16: begin
				x_s1 <= half_to_single(request.x_value[15:0]);
				y_s1 <= half_to_single(request.y_value[15:0]);
			end
			svacc_pkg::FMT_BF16: begin
				x_s1 <= {request.x_value[15:0], 16'b0};
				y_s1 <= {request.y_value[15:0], 16'b0};
			end
			default: begin
				x_s1 <= request.x_value;
				y_s1 <= request.y_value;
			end
		endcase
	end

	// stage 2: unpack x and scale, resolve product special cases
	logic [31:0] y_s2, pspec_val_s2;
	logic        pspec_s2;
	unp_t        xu_s2, su_s2;
	logic        psign;

	assign psign = x_s1[31] ^ scale_q[31];

	always_ff @(posedge clk) begin
		y_s2  <= y_s1;
		xu_s2 <= unpack_norm(x_s1);
		su_s2 <= unpack_norm(scale_q);
		pspec_s2 <= 1'b1;
		if (is_nan(x_s1)) begin
			pspec_val_s2 <= x_s1 | svacc_pkg::QUIET_BIT;
		end else if (is_nan(scale_q)) begin
			pspec_val_s2 <= scale_q | svacc_pkg::QUIET_BIT;
		end else if ((is_inf(x_s1) && scale_q[30:0] == '0) ||
				(is_inf(scale_q) && x_s1[30:0] == '0)) begin
			pspec_val_s2 <= svacc_pkg::DEFAULT_NAN;
		end else if (is_inf(x_s1) || is_inf(scale_q)) begin
			pspec_val_s2 <= {psign, 8'hFF, 23'b0};
		end else if (x_s1[30:0] == '0 || scale_q[30:0] == '0) begin
			pspec_val_s2 <= {psign, 31'b0};
		end else begin
			pspec_s2 <= 1'b0;
			pspec_val_s2 <= '0;
		end
	end

	// stage 3: mantissa multiply
	logic [31:0]       y_s3, pspec_val_s3;
	logic              pspec_s3, psign_s3;
	logic signed [11:0] pe_s3;
	logic [47:0]       prod_s3;

	always_ff @(posedge clk) begin
		y_s3 <= y_s2;
		pspec_s3 <= pspec_s2;
		pspec_val_s3 <= pspec_val_s2;
		psign_s3 <= xu_s2.sign ^ su_s2.sign;
		pe_s3 <= $signed({{2{xu_s2.exp[9]}}, xu_s2.exp}) +
			$signed({{2{su_s2.exp[9]}}, su_s2.exp}) - 12'sd127;
		prod_s3 <= xu_s2.mant * su_s2.mant;
	end

	// stage 4: normalize and round the product
	logic [47:0]        pn;
	logic signed [11:0] pe_n, shw;
	logic [5:0]         shm1;
	logic [47:0]        pr1;
	logic               pst, prup;
	logic [23:0]        pm;
	logic [7:0]         pbase;
	logic [31:0]        ptot, pbits;

	always_comb begin
		pn = prod_s3[47] ? prod_s3 : {prod_s3[46:0], 1'b0};
		pe_n = pe_s3 + $signed({11'b0, prod_s3[47]});
		shw = (pe_n >= 12'sd1) ? 12'sd23 : (12'sd24 - pe_n);
		shm1 = (shw > 12'sd49) ? 6'd49 : shw[5:0];
		pr1 = pn >> shm1;
		pst = |(pn & ~({48{1'b1}} << shm1));
		pm = pr1[24:1];
		prup = pr1[0] & (pst | pm[0]);
		pbase = (pe_n >= 12'sd1) ? pe_n[7:0] - 8'd1 : 8'd0;
		ptot = {1'b0, pbase, 23'b0} + {8'b0, pm} + {31'b0, prup};
		if (pspec_s3) begin
			pbits = pspec_val_s3;
		end else if (pe_n >= 12'sd255 || ptot[31] || ptot[30:23] == 8'hFF) begin
			pbits = {psign_s3, 8'hFF, 23'b0};
		end else begin
			pbits = {psign_s3, ptot[30:0]};
		end
	end

	logic [31:0] y_s4, p_s4;

	always_ff @(posedge clk) begin
		y_s4 <= y_s3;
		p_s4 <= pbits;
	end

	// stage 5: sum special cases, order by magnitude, align the smaller operand
	logic [31:0] big, lit;
	logic [7:0]  eb, el, ed;
	logic [26:0] mlx, mlsh;
	logic        mlst;

	always_comb begin
		if (p_s4[30:0] > y_s4[30:0]) begin
			big = p_s4;
			lit = y_s4;
		end else begin
			big = y_s4;
			lit = p_s4;
		end
		eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		el = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
		ed = eb - el;
		mlx = {lit[30:23] != 8'd0, lit[22:0], 3'b0};
		mlst = 1'b0;
		if (ed >= 8'd27) begin
			mlsh = {26'b0, |mlx};
		end else begin
			mlsh = mlx >> ed;
			mlst = |(mlx & ~({27{1'b1}} << ed));
			mlsh[0] = mlsh[0] | mlst;
		end
	end

	logic [31:0] aspec_val_s5;
	logic        aspec_s5, asign_s5, sub_s5;
	logic [7:0]  ea_s5;
	logic [26:0] ma_s5, mb_s5;

	always_ff @(posedge clk) begin
		aspec_s5 <= 1'b1;
		if (is_nan(y_s4)) begin
			aspec_val_s5 <= y_s4 | svacc_pkg::QUIET_BIT;
		end else if (is_nan(p_s4)) begin
			aspec_val_s5 <= p_s4 | svacc_pkg::QUIET_BIT;
		end else if (is_inf(y_s4) && is_inf(p_s4) && (y_s4[31] != p_s4[31])) begin
			aspec_val_s5 <= svacc_pkg::DEFAULT_NAN;
		end else if (is_inf(y_s4)) begin
			aspec_val_s5 <= y_s4;
		end else if (is_inf(p_s4)) begin
			aspec_val_s5 <= p_s4;
		end else begin
			aspec_s5 <= 1'b0;
			aspec_val_s5 <= '0;
		end
		asign_s5 <= big[31];
		sub_s5 <= big[31] ^ lit[31];
		ea_s5 <= eb;
		ma_s5 <= {big[30:23] != 8'd0, big[22:0], 3'b0};
		mb_s5 <= mlsh;
	end

	// stage 6: add or subtract magnitudes
	logic [31:0] aspec_val_s6;
	logic        aspec_s6, asign_s6, sub_s6;
	logic [7:0]  ea_s6;
	logic [27:0] sum_s6;

	always_ff @(posedge clk) begin
		aspec_s6 <= aspec_s5;
		aspec_val_s6 <= aspec_val_s5;
		asign_s6 <= asign_s5;
		sub_s6 <= sub_s5;
		ea_s6 <= ea_s5;
		sum_s6 <= sub_s5 ? ({1'b0, ma_s5} - {1'b0, mb_s5}) : ({1'b0, ma_s5} + {1'b0, mb_s5});
	end

	// stage 7: normalize the sum, never below the smallest exponent
	logic [4:0]  slz;
	logic        sfound;
	logic [7:0]  slim, ssh;
	logic [26:0] snorm;
	logic [8:0]  se;

	always_comb begin
		slz = 5'd27;
		sfound = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!sfound && sum_s6[i]) begin
				slz = 5'(26 - i);
				sfound = 1'b1;
			end
		end
		slim = ea_s6 - 8'd1;
		ssh = ({3'b0, slz} < slim) ? {3'b0, slz} : slim;
		if (sum_s6[27]) begin
			snorm = {sum_s6[27:2], sum_s6[1] | sum_s6[0]};
			se = {1'b0, ea_s6} + 9'd1;
		end else begin
			snorm = sum_s6[26:0] << ssh;
			se = {1'b0, ea_s6} - {1'b0, ssh};
		end
	end

	logic [31:0] aspec_val_s7;
	logic        aspec_s7, asign_s7, zero_s7, zsign_s7;
	logic [26:0] t_s7;
	logic [8:0]  e_s7;

	always_ff @(posedge clk) begin
		aspec_s7 <= aspec_s6;
		aspec_val_s7 <= aspec_val_s6;
		asign_s7 <= asign_s6;
		zero_s7 <= (sum_s6 == '0);
		zsign_s7 <= asign_s6 & ~sub_s6;
		t_s7 <= snorm;
		e_s7 <= se;
	end

	// stage 8: round the sum to fp32
	logic        srup;
	logic [31:0] stot, sbits;

	always_comb begin
		srup = t_s7[2] & (t_s7[1] | t_s7[0] | t_s7[3]);
		stot = {e_s7 - 9'd1, 23'b0} + {8'b0, t_s7[26:3]} + {31'b0, srup};
		if (aspec_s7) begin
			sbits = aspec_val_s7;
		end else if (zero_s7) begin
			sbits = {zsign_s7, 31'b0};
		end else if (stot[31] || stot[30:23] == 8'hFF) begin
			sbits = {asign_s7, 8'hFF, 23'b0};
		end else begin
			sbits = {asign_s7, stot[30:0]};
		end
	end

	logic [31:0] f_s8;

	always_ff @(posedge clk) begin
		f_s8 <= sbits;
	end

	// stage 9: narrow to the element format
	svacc_pkg::result_t res_s9;

	always_ff @(posedge clk) begin
		res_s9.last_out <= ctl_s8.last;
		case (ctl_s8.fmt)
			svacc_pkg::FMT_FP16: res_s9.sum_value <= {16'b0, single_to_half(f_s8)};
			svacc_pkg::FMT_BF16: res_s9.sum_value <= {16'b0, single_to_bf16(f_s8)};
			default:             res_s9.sum_value <= f_s8;
		endcase
	end

	assign done   = v_s9;
	assign result = res_s9;

endmodule

>>> rtl/svacc_checker.sv
// svacc_checker: port-level assertions for scaled_vector_accumulate_core
// depends on svacc_pkg (types, pipeline depth); bound to the core below
module svacc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input svacc_pkg::request_t request,
	input logic                done,
	input svacc_pkg::result_t  result
);

	// every taken request yields a result after the pipeline depth
	a_req_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##(svacc_pkg::PIPE_DEPTH) done)
		else $error("request without result");

	// no result without a request taken earlier
	a_result_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, svacc_pkg::PIPE_DEPTH))
		else $error("result without request");

	// last mark travels with its element
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.last_out == $past(request.last_element, svacc_pkg::PIPE_DEPTH))
		else $error("last mark out of order");

endmodule

bind scaled_vector_accumulate_core svacc_checker u_svacc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.request (request),
	.done    (done),
	.result  (result)
);

>>> tb/tb_scaled_vector_accumulate_core.sv
// tb_scaled_vector_accumulate_core: self-checking bench for the y + scale*x core
// bit-exact fp32 predictor built from integer operations, APB register setup
// depends on svacc_pkg and scaled_vector_accumulate_core
module tb_scaled_vector_accumulate_core;
	timeunit 1ns;
	timeprecision 1ps;
	import svacc_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_ITEMS = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start = 1'b0;
	logic        busy;
	request_t    request = '0;
	logic        done;
	result_t     result;

	// shadow of the block's registers
	logic [1:0]  cur_format = FMT_FP32;
	logic [31:0] cur_scale = SCALE_RESET;

	request_t    pending_reqs[$];
	result_t     expected_sums[$];
	int          send_idle_pct = 0;
	int          fail_count = 0;
	int          cycle_count = 0;

	scaled_vector_accumulate_core DUT (.*);

	always #5 clk = ~clk;

	// ---------------- fp32 arithmetic on bit patterns ----------------

	function automatic logic is_nan(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 0;
	endfunction

	// round a value sig * 2^e2 to fp32, nearest even, subnormals kept
	function automatic logic [31:0] round_pack(logic s, logic [95:0] sig, int e2);
		int p;
		int sh;
		int be;
		logic [95:0] m;
		logic [95:0] rem;
		logic [95:0] half;
		if (sig == 0) return {s, 31'b0};
		p = 95;
		while (!sig[p]) p--;
		sh = p - 23;
		if (sh < -149 - e2) sh = -149 - e2;
		if (sh >= 97) return {s, 31'b0};
		if (sh > 0) begin
			m = sig >> sh;
			rem = sig & ((96'b1 << sh) - 96'b1);
			half = 96'b1 << (sh - 1);
			if (rem > half || (rem == half && m[0])) m = m + 1;
		end else begin
			m = sig << (-sh);
		end
		if (m[24]) begin
			m = m >> 1;
			sh++;
		end
		if (!m[23]) return {s, 8'b0, m[22:0]};
		be = e2 + sh + 150;
		if (be >= 255) return {s, 8'hFF, 23'b0};
		return {s, be[7:0], m[22:0]};
	endfunction

	function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
		logic a_inf;
		logic b_inf;
		logic a_zero;
		logic b_zero;
		logic s;
		logic [23:0] ma;
		logic [23:0] mb;
		int ea;
		int eb;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		a_inf = a[30:0] == 31'h7F800000;
		b_inf = b[30:0] == 31'h7F800000;
		a_zero = a[30:0] == 0;
		b_zero = b[30:0] == 0;
		s = a[31] ^ b[31];
		if ((a_inf && b_zero) || (b_inf && a_zero)) return DEFAULT_NAN;
		if (a_inf || b_inf) return {s, 8'hFF, 23'b0};
		ma = (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
		mb = (b[30:23] == 0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		return round_pack(s, 96'(ma) * 96'(mb), ea + eb - 300);
	endfunction

	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] t;
		logic [95:0] big;
		logic [95:0] tiny;
		logic [95:0] sig;
		logic s;
		int ea;
		int eb;
		int d;
		if (is_nan(a)) return a | QUIET_BIT;
		if (is_nan(b)) return b | QUIET_BIT;
		if (a[30:0] == 31'h7F800000 && b[30:0] == 31'h7F800000)
			return (a[31] != b[31]) ? DEFAULT_NAN : a;
		if (a[30:0] == 31'h7F800000) return a;
		if (b[30:0] == 31'h7F800000) return b;
		// larger exponent first
		if (b[30:23] > a[30:23]) begin
			t = a;
			a = b;
			b = t;
		end
		ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
		eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
		d = ea - eb;
		big = 96'({a[30:23] != 0, a[22:0]}) << 60;
		tiny = 96'({b[30:23] != 0, b[22:0]});
		if (d <= 60) tiny = tiny << (60 - d);
		else tiny = (tiny != 0) ? 96'd1 : 96'd0;
		if (a[31] == b[31]) begin
			sig = big + tiny;
			s = a[31];
		end else if (big >= tiny) begin
			sig = big - tiny;
			s = a[31];
		end else begin
			sig = tiny - big;
			s = b[31];
		end
		// exact zero sum is negative only when both operands are
		if (sig == 0) s = a[31] & b[31];
		return round_pack(s, sig, ea - 210);
	endfunction

	// ---------------- format conversions ----------------

	function automatic logic [31:0] widen_half(logic [15:0] h);
		logic [31:0] sign;
		logic [9:0] m;
		logic [10:0] mm;
		int e32;
		sign = {h[15], 31'b0};
		m = h[9:0];
		if (h[14:10] == 5'h1F)
			return (m != 0) ? (sign | 32'h7F800000 | QUIET_BIT | (32'(m) << 13))
				: (sign | 32'h7F800000);
		if (h[14:10] == 0) begin
			if (m == 0) return sign;
			e32 = 113;
			mm = {1'b0, m};
			while (!mm[10]) begin
				mm = mm << 1;
				e32--;
			end
			return sign | (32'(e32) << 23) | (32'(mm[9:0]) << 13);
		end
		return sign | (32'(int'(h[14:10]) + 112) << 23) | (32'(m) << 13);
	endfunction

	function automatic logic [15:0] narrow_half(logic [31:0] b);
		logic [15:0] sign;
		logic [22:0] m;
		logic [31:0] v;
		logic [31:0] rem;
		logic [31:0] half;
		logic [31:0] full;
		int e;
		int e16;
		int sh;
		sign = {b[31], 15'b0};
		e = int'(b[30:23]);
		m = b[22:0];
		e16 = e - 112;
		if (e == 255) return (m != 0) ? (sign | 16'h7E00 | 16'(m >> 13)) : (sign | 16'h7C00);
		if (e16 >= 31) return sign | 16'h7C00;
		if (e16 >= 1) begin
			v = (32'(e16) << 10) | 32'(m >> 13);
			rem = 32'(m) & 32'h1FFF;
			if (rem > 32'h1000 || (rem == 32'h1000 && v[0])) v = v + 1;
			return sign | v[15:0];
		end
		if (e == 0) return sign;
		sh = 14 - e16;
		if (sh > 24) return sign;
		full = 32'(m) | 32'h800000;
		v = full >> sh;
		rem = full & ((32'd1 << sh) - 1);
		half = 32'd1 << (sh - 1);
		if (rem > half || (rem == half && v[0])) v = v + 1;
		return sign | v[15:0];
	endfunction

	function automatic logic [15:0] narrow_bf16(logic [31:0] b);
		logic [31:0] r;
		if (is_nan(b)) return b[31:16] | 16'h0040;
		r = b + 32'h7FFF + 32'(b[16]);
		return r[31:16];
	endfunction

	// expected sum for one request under the current registers
	function automatic result_t saxpy_predict(request_t rq);
		logic [31:0] xs;
		logic [31:0] ys;
		logic [31:0] acc;
		result_t r;
		case (cur_format)
			FMT_FP16: begin
				xs = widen_half(rq.x_value[15:0]);
				ys = widen_half(rq.y_value[15:0]);
			end
			FMT_BF16: begin
				xs = {rq.x_value[15:0], 16'b0};
				ys = {rq.y_value[15:0], 16'b0};
			end
			default: begin
				xs = rq.x_value;
				ys = rq.y_value;
			end
		endcase
		acc = fp_add(ys, fp_mul(xs, cur_scale));
		case (cur_format)
			FMT_FP16: r.sum_value = {16'b0, narrow_half(acc)};
			FMT_BF16: r.sum_value = {16'b0, narrow_bf16(acc)};
			default:  r.sum_value = acc;
		endcase
		r.last_out = rq.last_element;
		return r;
	endfunction

	// random element biased toward zeros, infinities, NaNs, subnormals and near-one values
	function automatic logic [31:0] rand_element(logic [1:0] fmt);
		int ew;
		int mw;
		int emax;
		int bias;
		int kind;
		logic [31:0] ex;
		logic [31:0] man;
		logic [31:0] bits;
		ew = (fmt == FMT_FP16) ? 5 : 8;
		mw = (fmt == FMT_FP16) ? 10 : (fmt == FMT_BF16) ? 7 : 23;
		emax = (1 << ew) - 1;
		bias = emax >> 1;
		kind = $urandom_range(0, 9);
		case (kind)
			0: ex = 0;
			1: ex = emax;
			2: ex = emax - 1;
			3: ex = 1;
			4, 5, 6: ex = $urandom_range(bias - 3, bias + 3);
			default: ex = $urandom_range(0, emax);
		endcase
		man = $urandom & ((32'd1 << mw) - 1);
		if ($urandom_range(0, 3) == 0) man = 0;
		if (kind == 7) man = (32'd1 << mw) - 1;
		bits = (32'($urandom_range(0, 1)) << (ew + mw)) | (ex << mw) | man;
		// upper half is don't-care in the 16-bit formats
		if (ew + mw < 31) bits[31:16] = $urandom;
		return bits;
	endfunction

	// ---------------- request driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) expected_sums.push_back(saxpy_predict(request));
			if (!start || !busy) begin
				if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					request <= pending_reqs.pop_front();
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_sums.size() == 0) begin
				$error("unexpected result sum_value %h last_out %b",
					result.sum_value, result.last_out);
				fail_count++;
			end else begin
				want = expected_sums.pop_front();
				if (result.sum_value !== want.sum_value) begin
					$error("sum_value expected %h got %h", want.sum_value, result.sum_value);
					fail_count++;
				end
				if (result.last_out !== want.last_out) begin
					$error("last_out expected %b got %b", want.last_out, result.last_out);
					fail_count++;
				end
			end
		end
	end

	// ---------------- run limit ----------------
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** scaled_vector_accumulate_core: FAILED **");
			$finish;
		end
	end

	task automatic reg_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_FORMAT) cur_format = data[1:0];
		else cur_format = cur_format;
		if (addr == ADDR_SCALE) cur_scale = data;
	endtask

	task automatic add_request(logic [31:0] xv, logic [31:0] yv, logic lst);
		request_t rq;
		rq.x_value = xv;
		rq.y_value = yv;
		rq.last_element = lst;
		pending_reqs.push_back(rq);
	endtask

	// wait for the pipeline to drain before touching registers
	task automatic drain();
		while (pending_reqs.size() > 0 || start || expected_sums.size() > 0) @(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	// ---------------- stimulus ----------------
	initial begin
		logic [31:0] scale_pick[RAND_PHASES];
		scale_pick = '{32'h3F80_0000, 32'h0000_0000, 32'h7F80_0000, 32'hFFFF_FFFF,
			32'h7F7F_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hBFC0_0000,
			32'h7F80_0001, $urandom, 32'h4000_0000, $urandom};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at reset settings: fp32, scale 1.0
		send_idle_pct = 29;
		add_request(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_request(32'h8000_0000, 32'h8000_0000, 1'b1);
		add_request(32'h8000_0000, 32'h0000_0000, 1'b0);
		add_request(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
		add_request(32'h7F80_0000, 32'hFF80_0000, 1'b1);
		add_request(32'h7F80_0000, 32'h7F80_0000, 1'b0);
		add_request(32'h7F80_0001, 32'h3F80_0000, 1'b0);
		add_request(32'h3F80_0000, 32'hFFFF_FFFF, 1'b1);
		add_request(32'hFF80_0001, 32'h7F80_0002, 1'b0);
		add_request(32'h0000_0001, 32'h0000_0001, 1'b0);
		add_request(32'h0000_0001, 32'h8000_0000, 1'b1);
		add_request(32'h807F_FFFF, 32'h0000_0001, 1'b0);
		add_request(32'h3F80_0000, 32'hBF80_0000, 1'b0);
		add_request(32'h3F80_0001, 32'hBF80_0000, 1'b1);
		add_request(32'h4B80_0000, 32'h3F80_0000, 1'b0);
		add_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		add_request(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		add_request(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
		drain();

		// random passes: each format, including the unused code, under several scales
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			reg_write(ADDR_FORMAT, {$urandom_range(0, 1) ? 30'h3FFF_FFFF : 30'h0,
				2'(ph % 4)});
			reg_write(ADDR_SCALE, scale_pick[ph]);
			send_idle_pct = (ph < 4) ? 29 : (ph < 8) ? 69 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_request(rand_element(cur_format), rand_element(cur_format),
					1'($urandom_range(0, 1)));
			drain();
		end

		if (fail_count == 0) begin
			$display("** scaled_vector_accumulate_core: PASSED **");
		end else begin
			$display("** scaled_vector_accumulate_core: FAILED **");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/svacc_pkg.sv
rtl/scaled_vector_accumulate_core.sv
rtl/svacc_checker.sv
tb/tb_scaled_vector_accumulate_core.sv
